[rtl/lrpp_pkg.sv]
// ----------------------------------------------------------------------------
// Light refinement priority picker package
// Shared types and constants for the picker front end, queue and back end.
// ----------------------------------------------------------------------------
package lrpp_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STAGE_W     = 5;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    LS_NO_RESULTS = 2'd0,
    LS_PARTIAL    = 2'd1,
    LS_NEW        = 2'd2,
    LS_FULL       = 2'd3
  } incr_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_MIN_X = 3'd0,
    CFG_VIEW_MIN_Y = 3'd1,
    CFG_VIEW_MIN_Z = 3'd2,
    CFG_VIEW_MAX_X = 3'd3,
    CFG_VIEW_MAX_Y = 3'd4,
    CFG_VIEW_MAX_Z = 3'd5
  } cfg_reg_e;

  // One classified light record as it travels from the front end to the back end.
  typedef struct packed {
    incr_state_e         st;
    logic [STAGE_W-1:0]  stage;
    logic [DATA_W-1:0]   contrib;
    logic [DATA_W-1:0]   eye_dist;
    logic [DATA_W-1:0]   stamp;
    logic                hp;
    logic                last;
    logic [SLOT_W-1:0]   slot;
  } rec_t;

endpackage

[rtl/lrpp_if.sv]
// ----------------------------------------------------------------------------
// Light refinement priority picker channels
// Valid/ready channels for light records in and picked results out.
// ----------------------------------------------------------------------------
interface lrpp_light_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          light_state;
  logic [lrpp_pkg::STAGE_W-1:0]        refine_stage;
  logic [lrpp_pkg::DATA_W-1:0]         contribution;
  logic [lrpp_pkg::DATA_W-1:0]         eye_distance;
  logic [lrpp_pkg::DATA_W-1:0]         last_lit_stamp;
  logic signed [lrpp_pkg::DATA_W-1:0]  pos_x;
  logic signed [lrpp_pkg::DATA_W-1:0]  pos_y;
  logic signed [lrpp_pkg::DATA_W-1:0]  pos_z;
  logic                                is_last;

  modport source (
    output valid, light_state, refine_stage, contribution, eye_distance,
           last_lit_stamp, pos_x, pos_y, pos_z, is_last,
    input  ready
  );
  modport sink (
    input  valid, light_state, refine_stage, contribution, eye_distance,
           last_lit_stamp, pos_x, pos_y, pos_z, is_last,
    output ready
  );
endinterface

interface lrpp_result_if;
  logic                          valid;
  logic                          ready;
  logic [lrpp_pkg::SLOT_W-1:0]   best_index;
  logic                          any_work;

  modport source (output valid, best_index, any_work, input ready);
  modport sink (input valid, best_index, any_work, output ready);
endinterface

[rtl/lrpp_front.sv]
// ----------------------------------------------------------------------------
// Light refinement priority picker front end
// Holds the view box, numbers the records of a list and flags in-view new
// lights, then hands each record to the queue through one register stage.
// ----------------------------------------------------------------------------
module lrpp_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lrpp_pkg::DATA_W-1:0]       cfg_data_i,
  lrpp_light_if.sink                        light_i,
  output logic                              push_valid_o,
  output lrpp_pkg::rec_t                    push_rec_o,
  input  logic                              push_ready_i
);

  logic signed [lrpp_pkg::DATA_W-1:0] vmin_x_q, vmin_y_q, vmin_z_q;
  logic signed [lrpp_pkg::DATA_W-1:0] vmax_x_q, vmax_y_q, vmax_z_q;
  logic [lrpp_pkg::SLOT_W-1:0]        cnt_q, cnt_d;
  logic                               fv_q, fv_d;
  lrpp_pkg::rec_t                     frec_q, frec_d;
  logic                               in_fire;
  logic                               in_box;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_x_q <= '0;
      vmin_y_q <= '0;
      vmin_z_q <= '0;
      vmax_x_q <= '0;
      vmax_y_q <= '0;
      vmax_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lrpp_pkg::cfg_reg_e'(cfg_idx_i))
        lrpp_pkg::CFG_VIEW_MIN_X: vmin_x_q <= cfg_data_i;
        lrpp_pkg::CFG_VIEW_MIN_Y: vmin_y_q <= cfg_data_i;
        lrpp_pkg::CFG_VIEW_MIN_Z: vmin_z_q <= cfg_data_i;
        lrpp_pkg::CFG_VIEW_MAX_X: vmax_x_q <= cfg_data_i;
        lrpp_pkg::CFG_VIEW_MAX_Y: vmax_y_q <= cfg_data_i;
        lrpp_pkg::CFG_VIEW_MAX_Z: vmax_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign light_i.ready = !fv_q || push_ready_i;
  assign in_fire       = light_i.valid && light_i.ready;

  // Both bounds are inclusive; an inverted box never holds a light.
  assign in_box = (light_i.pos_x >= vmin_x_q) && (light_i.pos_x <= vmax_x_q) &&
                  (light_i.pos_y >= vmin_y_q) && (light_i.pos_y <= vmax_y_q) &&
                  (light_i.pos_z >= vmin_z_q) && (light_i.pos_z <= vmax_z_q);

  always_comb begin
    cnt_d  = cnt_q;
    fv_d   = fv_q;
    frec_d = frec_q;
    if (fv_q && push_ready_i) begin
      fv_d = 1'b0;
    end
    if (in_fire) begin
      fv_d            = 1'b1;
      frec_d.st       = lrpp_pkg::incr_state_e'(light_i.light_state);
      frec_d.stage    = light_i.refine_stage;
      frec_d.contrib  = light_i.contribution;
      frec_d.eye_dist = light_i.eye_distance;
      frec_d.stamp    = light_i.last_lit_stamp;
      frec_d.hp       = (light_i.light_state == lrpp_pkg::LS_NEW) && in_box;
      frec_d.last     = light_i.is_last;
      frec_d.slot     = cnt_q;
      cnt_d           = light_i.is_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      fv_q  <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frec_q <= frec_d;
  end

  assign push_valid_o = fv_q;
  assign push_rec_o   = frec_q;

endmodule

[rtl/lrpp_queue.sv]
// ----------------------------------------------------------------------------
// Light refinement priority picker queue
// Small first-in first-out buffer of classified records between the front
// end and the back end.
// ----------------------------------------------------------------------------
module lrpp_queue #(
  parameter int unsigned DEPTH = lrpp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  lrpp_pkg::rec_t  push_rec_i,
  output logic            push_ready_o,
  output logic            head_valid_o,
  output lrpp_pkg::rec_t  head_rec_o,
  input  logic            pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lrpp_pkg::rec_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign head_valid_o = (cnt_q != '0);
  assign head_rec_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_rec_i;
    end
  end

endmodule

[rtl/lrpp_back.sv]
// ----------------------------------------------------------------------------
// Light refinement priority picker back end
// Compares each queued record against the best one held so far and loads
// the output register when the last record of a list goes by.
// ----------------------------------------------------------------------------
module lrpp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  lrpp_pkg::rec_t  head_rec_i,
  output logic            pop_o,
  lrpp_result_if.source   result_o
);

  // With both lights dark the more recently lit wins, otherwise the brighter.
  function automatic logic dim_or_older(lrpp_pkg::rec_t a, lrpp_pkg::rec_t b);
    if (a.contrib == '0 && b.contrib == '0) begin
      return b.stamp > a.stamp;
    end
    return a.contrib < b.contrib;
  endfunction

  // True when a has lower priority than b.
  function automatic logic lower_prio(lrpp_pkg::rec_t a, lrpp_pkg::rec_t b);
    logic                        a_dark, b_dark;
    logic [lrpp_pkg::STAGE_W-1:0] d;
    logic                        res;
    a_dark = (a.contrib == '0);
    b_dark = (b.contrib == '0);
    d      = (a.stage > b.stage) ? a.stage - b.stage : b.stage - a.stage;
    res    = 1'b0;
    if (a.hp && !b.hp) begin
      res = 1'b0;
    end else if (b.hp && !a.hp) begin
      res = 1'b1;
    end else begin
      unique case (a.st)
        lrpp_pkg::LS_NEW: begin
          unique case (b.st)
            lrpp_pkg::LS_NEW:        res = a.eye_dist > b.eye_dist;
            lrpp_pkg::LS_NO_RESULTS: res = !b_dark;
            default:                 res = 1'b0;
          endcase
        end
        lrpp_pkg::LS_PARTIAL: begin
          unique case (b.st)
            lrpp_pkg::LS_NEW: res = 1'b1;
            lrpp_pkg::LS_PARTIAL: begin
              priority if (a_dark && b_dark && (b.stamp > a.stamp)) begin
                res = 1'b1;
              end else if (b_dark && !a_dark) begin
                res = 1'b0;
              end else if (a_dark && !b_dark) begin
                res = 1'b1;
              end else if (d <= lrpp_pkg::STAGE_W'(1)) begin
                res = a.contrib < b.contrib;
              end else begin
                res = a.stage > b.stage;
              end
            end
            lrpp_pkg::LS_NO_RESULTS: res = !b_dark || dim_or_older(a, b);
            default:                 res = 1'b0;
          endcase
        end
        lrpp_pkg::LS_NO_RESULTS: begin
          unique case (b.st)
            lrpp_pkg::LS_NEW:        res = a_dark;
            lrpp_pkg::LS_PARTIAL:    res = a_dark && dim_or_older(a, b);
            lrpp_pkg::LS_NO_RESULTS: res = dim_or_older(a, b);
            default:                 res = 1'b0;
          endcase
        end
        default: res = 1'b0;
      endcase
    end
    return res;
  endfunction

  lrpp_pkg::rec_t               best_q, best_d;
  logic                         have_q, have_d;
  logic                         ov_q, ov_d;
  logic [lrpp_pkg::SLOT_W-1:0]  idx_q, idx_d;
  logic                         any_q, any_d;
  logic                         out_free;
  logic                         take;

  assign out_free = !ov_q || result_o.ready;
  assign pop_o    = head_valid_i && (!head_rec_i.last || out_free);
  assign take     = (head_rec_i.st != lrpp_pkg::LS_FULL) &&
                    (!have_q || lower_prio(best_q, head_rec_i));

  always_comb begin
    best_d = best_q;
    have_d = have_q;
    ov_d   = ov_q;
    idx_d  = idx_q;
    any_d  = any_q;
    if (ov_q && result_o.ready) begin
      ov_d = 1'b0;
    end
    if (pop_o) begin
      if (take) begin
        best_d = head_rec_i;
        have_d = 1'b1;
      end
      if (head_rec_i.last) begin
        ov_d   = 1'b1;
        any_d  = have_q || take;
        idx_d  = take ? head_rec_i.slot : (have_q ? best_q.slot : '0);
        have_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      have_q <= have_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    idx_q  <= idx_d;
    any_q  <= any_d;
  end

  assign result_o.valid      = ov_q;
  assign result_o.best_index = idx_q;
  assign result_o.any_work   = any_q;

endmodule

[rtl/light_refinement_priority_picker.sv]
// ----------------------------------------------------------------------------
// Light refinement priority picker
// Streams light records and reports which light to refine next per list.
// ----------------------------------------------------------------------------
// Throughput: one record per cycle while the result channel does not hold back a last
// record, set by the single compare of the back end. A last record passes the front
// register and the queue before the output register loads its result.
// Reset: view box registers go to zero, list numbering and best candidate are
// cleared; the list state also clears itself after every last record.
module light_refinement_priority_picker #(
  parameter int unsigned QUEUE_DEPTH = lrpp_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lrpp_pkg::DATA_W-1:0]     cfg_data_i,
  lrpp_light_if.sink                      light_i,
  lrpp_result_if.source                   result_o
);

  logic            push_valid;
  logic            push_ready;
  lrpp_pkg::rec_t  push_rec;
  logic            head_valid;
  lrpp_pkg::rec_t  head_rec;
  logic            pop;

  lrpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .light_i      (light_i),
    .push_valid_o (push_valid),
    .push_rec_o   (push_rec),
    .push_ready_i (push_ready)
  );

  lrpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_rec_i   (push_rec),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_rec_o   (head_rec),
    .pop_i        (pop)
  );

  lrpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_rec_i   (head_rec),
    .pop_o        (pop),
    .result_o     (result_o)
  );

`ifndef ASSERT_OFF
  // A list without work always reports slot zero.
  a_no_work_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.any_work) |-> (result_o.best_index == '0))
    else $error("no-work result carries a nonzero index");

  // Retiring the last record of a list must load the output register.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_rec.last) |=> result_o.valid)
    else $error("last record retired without a result");

  // A full queue can never be empty at the head.
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready |-> head_valid)
    else $error("queue reports full with no head entry");

  // The back end only retires records the queue actually holds.
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop without a queued record");
`endif

endmodule

[bench/tb_light_refinement_priority_picker.sv]
// ----------------------------------------------------------------------------
// Light refinement priority picker testbench
// Streams lists of light records into the picker while both channels stall at
// random, predicts the chosen light of every list and compares each result.
// ----------------------------------------------------------------------------
module tb_light_refinement_priority_picker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS  = 300;
  localparam int N_PHASES     = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 3000;

  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;

  typedef struct {
    lrpp_pkg::incr_state_e st;
    logic [4:0]            stage;
    logic [31:0]           contrib;
    logic [31:0]           eye_dist;
    logic [31:0]           stamp;
    logic signed [31:0]    px;
    logic signed [31:0]    py;
    logic signed [31:0]    pz;
    logic                  last;
  } light_item_t;

  typedef struct packed {
    lrpp_pkg::incr_state_e st;
    logic [4:0]            stage;
    logic [31:0]           contrib;
    logic [31:0]           eye_dist;
    logic [31:0]           stamp;
    logic                  hp;
  } lead_rec_t;

  typedef struct packed {
    logic [7:0] slot;
    logic       any_work;
  } pick_t;

  typedef struct {
    light_item_t item;
    bit          typed;
    pick_t       want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  lrpp_pkg::cfg_reg_e cfg_idx_i;
  logic [lrpp_pkg::DATA_W-1:0] cfg_data_i;

  lrpp_light_if  lin ();
  lrpp_result_if rout ();

  light_refinement_priority_picker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .light_i    (lin),
    .result_o   (rout)
  );

  // Predictor state: view box, list position and the light currently leading.
  logic signed [31:0] view_lo [3];
  logic signed [31:0] view_hi [3];
  logic [7:0]         list_pos;
  bit                 have_lead;
  logic [7:0]         lead_slot;
  lead_rec_t          lead;

  pick_t    picks_due [$];
  int       mismatch_count;
  int       send_idle_pct;
  int       recv_idle_pct;
  dir_row_t dir_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit in_view(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
    return x >= view_lo[0] && x <= view_hi[0] &&
           y >= view_lo[1] && y <= view_hi[1] &&
           z >= view_lo[2] && z <= view_hi[2];
  endfunction

  // When both are dark the more recently lit one wins, otherwise the brighter.
  function automatic bit dark_or_stale(lead_rec_t a, lead_rec_t b);
    if (a.contrib == 0 && b.contrib == 0) return b.stamp > a.stamp;
    return a.contrib < b.contrib;
  endfunction

  // True when the held light a ranks below the candidate b.
  function automatic bit loses_to(lead_rec_t a, lead_rec_t b);
    int gap;
    if (a.hp && !b.hp) return 1'b0;
    if (b.hp && !a.hp) return 1'b1;
    case (a.st)
      lrpp_pkg::LS_NEW: begin
        case (b.st)
          lrpp_pkg::LS_NEW:        return a.eye_dist > b.eye_dist;
          lrpp_pkg::LS_NO_RESULTS: return b.contrib != 0;
          default:                 return 1'b0;
        endcase
      end
      lrpp_pkg::LS_PARTIAL: begin
        case (b.st)
          lrpp_pkg::LS_NEW: return 1'b1;
          lrpp_pkg::LS_PARTIAL: begin
            if (a.contrib == 0 && b.contrib == 0 && b.stamp > a.stamp) return 1'b1;
            if (b.contrib == 0 && a.contrib != 0) return 1'b0;
            if (a.contrib == 0 && b.contrib != 0) return 1'b1;
            gap = (a.stage > b.stage) ? int'(a.stage - b.stage) : int'(b.stage - a.stage);
            if (gap <= 1) return a.contrib < b.contrib;
            return a.stage > b.stage;
          end
          lrpp_pkg::LS_NO_RESULTS: begin
            if (b.contrib != 0) return 1'b1;
            return dark_or_stale(a, b);
          end
          default: return 1'b0;
        endcase
      end
      lrpp_pkg::LS_NO_RESULTS: begin
        case (b.st)
          lrpp_pkg::LS_NEW: return a.contrib == 0;
          lrpp_pkg::LS_PARTIAL: begin
            if (a.contrib != 0) return 1'b0;
            return dark_or_stale(a, b);
          end
          lrpp_pkg::LS_NO_RESULTS: return dark_or_stale(a, b);
          default: return 1'b0;
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  // Advances the predicted list by one accepted light; a last light closes it.
  task automatic track_light(input light_item_t it, output bit done, output pick_t pick);
    lead_rec_t cand;
    cand.st       = it.st;
    cand.stage    = it.stage;
    cand.contrib  = it.contrib;
    cand.eye_dist = it.eye_dist;
    cand.stamp    = it.stamp;
    cand.hp       = (it.st == lrpp_pkg::LS_NEW) && in_view(it.px, it.py, it.pz);
    done = 1'b0;
    pick = '0;
    if (it.st != lrpp_pkg::LS_FULL) begin
      if (!have_lead || loses_to(lead, cand)) begin
        have_lead = 1'b1;
        lead_slot = list_pos;
        lead      = cand;
      end
    end
    list_pos = list_pos + 8'd1;
    if (it.last) begin
      done          = 1'b1;
      pick.slot     = have_lead ? lead_slot : 8'd0;
      pick.any_work = have_lead;
      list_pos      = '0;
      have_lead     = 1'b0;
      lead_slot     = '0;
      lead          = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(input lrpp_pkg::cfg_reg_e idx, input logic signed [31:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      lrpp_pkg::CFG_VIEW_MIN_X: view_lo[0] = val;
      lrpp_pkg::CFG_VIEW_MIN_Y: view_lo[1] = val;
      lrpp_pkg::CFG_VIEW_MIN_Z: view_lo[2] = val;
      lrpp_pkg::CFG_VIEW_MAX_X: view_hi[0] = val;
      lrpp_pkg::CFG_VIEW_MAX_Y: view_hi[1] = val;
      lrpp_pkg::CFG_VIEW_MAX_Z: view_hi[2] = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_light(input light_item_t it, input bit typed, input pick_t want);
    bit    done;
    pick_t pick;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      lin.valid = 1'b0;
      @(negedge clk_i);
    end
    lin.light_state    = it.st;
    lin.refine_stage   = it.stage;
    lin.contribution   = it.contrib;
    lin.eye_distance   = it.eye_dist;
    lin.last_lit_stamp = it.stamp;
    lin.pos_x          = it.px;
    lin.pos_y          = it.py;
    lin.pos_z          = it.pz;
    lin.is_last        = it.last;
    lin.valid          = 1'b1;
    do @(posedge clk_i); while (lin.ready !== 1'b1);
    track_light(it, done, pick);
    if (done) picks_due.push_back(typed ? want : pick);
    @(negedge clk_i);
  endtask

  // Sender holds off until every pending list result has been transferred.
  task automatic hold_until_drained();
    lin.valid = 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo,
                                                    logic signed [31:0] hi, bit aim);
    longint      span;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (aim && lo <= hi) begin
      if (r == 0) return lo;
      if (r == 1) return hi;
      span = longint'(hi) - longint'(lo) + 1;
      return lo + 32'(longint'({$urandom, $urandom} >> 1) % span);
    end
    if (r < 4) return $urandom;
    if (r < 6) return lo - 1;
    if (r < 8) return hi + 1;
    if (r == 8) return lo;
    return hi;
  endfunction

  function automatic light_item_t gen_light(bit last);
    light_item_t it;
    int unsigned r;
    bit          aim;
    r = $urandom_range(0, 9);
    it.st = (r < 2) ? lrpp_pkg::LS_FULL :
            (r < 4) ? lrpp_pkg::LS_NO_RESULTS :
            (r < 7) ? lrpp_pkg::LS_PARTIAL : lrpp_pkg::LS_NEW;
    r = $urandom_range(0, 3);
    it.stage = (r == 0) ? {5{$urandom_range(0, 1) == 1}} :
               (r == 1) ? 5'($urandom_range(14, 16)) : 5'($urandom_range(0, 31));
    r = $urandom_range(0, 9);
    it.contrib = (r < 4) ? 32'd0 : (r == 4) ? '1 :
                 (r < 7) ? 32'($urandom_range(1, 4)) : 32'($urandom);
    r = $urandom_range(0, 9);
    it.eye_dist = (r == 0) ? 32'd0 : (r == 1) ? '1 : (r == 2) ? 32'd100 : 32'($urandom);
    r = $urandom_range(0, 9);
    it.stamp = (r < 3) ? 32'($urandom_range(0, 3)) : (r == 3) ? '1 : 32'($urandom);
    aim = $urandom_range(0, 1);
    it.px   = pick_coord(view_lo[0], view_hi[0], aim);
    it.py   = pick_coord(view_lo[1], view_hi[1], aim);
    it.pz   = pick_coord(view_lo[2], view_hi[2], aim);
    it.last = last;
    return it;
  endfunction

  function automatic dir_row_t mk_row(lrpp_pkg::incr_state_e st, logic [4:0] stage,
                                      logic [31:0] contrib, logic [31:0] eye_dist,
                                      logic [31:0] stamp, logic signed [31:0] px,
                                      logic signed [31:0] py, logic signed [31:0] pz,
                                      logic last, bit typed = 1'b0,
                                      logic [7:0] slot = '0, logic any_work = 1'b0);
    dir_row_t row;
    row.item.st       = st;
    row.item.stage    = stage;
    row.item.contrib  = contrib;
    row.item.eye_dist = eye_dist;
    row.item.stamp    = stamp;
    row.item.px       = px;
    row.item.py       = py;
    row.item.pz       = pz;
    row.item.last     = last;
    row.typed         = typed;
    row.want.slot     = slot;
    row.want.any_work = any_work;
    return row;
  endfunction

  initial begin
    rout.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rout.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    pick_t want;
    if (rst_ni && rout.valid === 1'b1 && rout.ready === 1'b1) begin
      if (picks_due.size() == 0) begin
        flag_mismatch("result transfer with no list pending, best_index",
                      rout.best_index, 0);
      end else begin
        want = picks_due.pop_front();
        if (rout.any_work !== want.any_work)
          flag_mismatch("any_work", rout.any_work, want.any_work);
        if (rout.best_index !== want.slot)
          flag_mismatch("best_index", rout.best_index, want.slot);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((lin.valid === 1'b1 && lin.ready === 1'b1) ||
          (rout.valid === 1'b1 && rout.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] a;
    logic signed [31:0] b;
    int sent;
    int lists;
    int len;
    int r;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = lrpp_pkg::CFG_VIEW_MIN_X;
    cfg_data_i = '0;
    lin.valid          = 1'b0;
    lin.light_state    = '0;
    lin.refine_stage   = '0;
    lin.contribution   = '0;
    lin.eye_distance   = '0;
    lin.last_lit_stamp = '0;
    lin.pos_x          = '0;
    lin.pos_y          = '0;
    lin.pos_z          = '0;
    lin.is_last        = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 15;
    recv_idle_pct  = 49;
    for (int i = 0; i < 3; i++) begin
      view_lo[i] = '0;
      view_hi[i] = '0;
    end
    list_pos  = '0;
    have_lead = 1'b0;
    lead_slot = '0;
    lead      = '0;

    // The box resets to the single point at the origin, so only lights placed
    // exactly at the origin are in view during this part.
    dir_rows = {
      // every light full: no work
      mk_row(lrpp_pkg::LS_FULL, 5'd31, '1, '1, '1, SMIN, SMAX, SMIN,
             1'b1, 1'b1, 8'd0, 1'b0),
      mk_row(lrpp_pkg::LS_NEW, 5'd0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 8'd0, 1'b1),
      // full lights are skipped but still take a list position
      mk_row(lrpp_pkg::LS_FULL, 5'd0, 0, 0, 0, SMAX, SMIN, SMAX, 1'b0),
      mk_row(lrpp_pkg::LS_FULL, 5'd0, 0, 0, 0, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd3, 1, 2, 3, 0, 0, 0, 1'b1, 1'b1, 8'd2, 1'b1),
      // an in-view new light wins outright
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd16, '1, 5, 7, SMIN, SMIN, SMIN, 1'b0),
      mk_row(lrpp_pkg::LS_NEW, 5'd0, '1, 0, '1, SMAX, SMAX, SMAX, 1'b0),
      mk_row(lrpp_pkg::LS_NEW, 5'd1, 0, '1, 0, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_NO_RESULTS, 5'd31, '1, 0, 0, 0, 0, 0, 1'b1, 1'b1, 8'd2, 1'b1),
      // new against new decided by distance
      mk_row(lrpp_pkg::LS_NEW, 5'd0, 0, '1, 0, SMAX, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_NEW, 5'd31, '1, 0, 9, 0, SMIN, 0, 1'b1),
      // dark lights: the most recent stamp wins
      mk_row(lrpp_pkg::LS_NO_RESULTS, 5'd0, 0, 10, 5, SMIN, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_NO_RESULTS, 5'd0, 0, 10, '1, 0, 0, SMAX, 1'b0),
      mk_row(lrpp_pkg::LS_NO_RESULTS, 5'd0, 0, 10, 0, 0, 0, SMIN, 1'b1),
      // partial lights at near and far stages
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd0, 1, 4, 0, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd31, '1, 4, 0, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd30, 0, 4, 0, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd1, 2, 4, 0, 0, 0, 0, 1'b1),
      // mixed states, out-of-view new lights
      mk_row(lrpp_pkg::LS_NEW, 5'd5, 0, 1, 1, SMAX, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_NO_RESULTS, 5'd2, 0, 0, 3, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd4, 7, 0, 4, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_NO_RESULTS, 5'd6, '1, 3, 0, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_NEW, 5'd7, 0, 2, 2, 0, SMAX, 0, 1'b1),
      mk_row(lrpp_pkg::LS_PARTIAL, 5'd2, 0, 0, 8, 0, 0, 0, 1'b0),
      mk_row(lrpp_pkg::LS_NO_RESULTS, 5'd0, 0, 0, 9, 0, 0, 0, 1'b1)
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_light(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      send_idle_pct = (phase < 2) ? 15 : (phase < 4) ? 49 : 0;
      recv_idle_pct = (phase < 2) ? 49 : (phase < 4) ? 15 : 0;
      r = $urandom_range(0, 2);
      for (int ax = 0; ax < 3; ax++) begin
        a = $urandom;
        b = $urandom;
        case (phase)
          0: begin
            lo[ax] = SMIN;
            hi[ax] = SMAX;
          end
          1: begin
            lo[ax] = (a < b) ? a : b;
            hi[ax] = (a < b) ? b : a;
          end
          2: begin
            // one axis with its bounds swapped, so nothing is ever in view
            lo[ax] = (ax == r) ? ((a < b) ? b : a) : SMIN;
            hi[ax] = (ax == r) ? ((a < b) ? a : b) : SMAX;
            if (ax == r && a == b) hi[ax] = lo[ax] - 1;
          end
          3: begin
            lo[ax] = a;
            hi[ax] = a + $urandom_range(0, 15);
          end
          4: begin
            lo[ax] = a;
            hi[ax] = a;
          end
          default: begin
            lo[ax] = a;
            hi[ax] = b;
          end
        endcase
      end
      write_reg(lrpp_pkg::CFG_VIEW_MIN_X, lo[0]);
      write_reg(lrpp_pkg::CFG_VIEW_MIN_Y, lo[1]);
      write_reg(lrpp_pkg::CFG_VIEW_MIN_Z, lo[2]);
      write_reg(lrpp_pkg::CFG_VIEW_MAX_X, hi[0]);
      write_reg(lrpp_pkg::CFG_VIEW_MAX_Y, hi[1]);
      write_reg(lrpp_pkg::CFG_VIEW_MAX_Z, hi[2]);

      sent  = 0;
      lists = 0;
      while (sent < PHASE_ITEMS) begin
        r   = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(1, 6) :
              (r < 95) ? $urandom_range(7, 20) : $urandom_range(21, 40);
        // One list long enough for the position counter to wrap.
        if (phase == N_PHASES - 1 && lists == 3) len = 280;
        for (int k = 0; k < len; k++) send_light(gen_light(k == len - 1), 1'b0, '0);
        sent += len;
        lists++;
        if (lists % 12 == 0) hold_until_drained();
      end
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clk_i);
    end

    lin.valid = 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && picks_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
